### sv/cetk_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetk_pkg
// Shared widths, codes, control/status bundles and saturating add for the
// cell energy accumulator with top-k contributor list.
// ----------------------------------------------------------------------------
package cetk_pkg;

  // default list depth
  localparam int CETK_MAX_LABELS = 4;

  // field widths
  localparam int CELL_W     = 16;
  localparam int ENERGY_W   = 24;
  localparam int TIME_W     = 16;
  localparam int LABEL_W    = 21;
  localparam int ACC_W      = 32;
  localparam int USED_W     = 5;
  localparam int SLOT_IDX_W = 4;

  // APB register file
  localparam int CFG_ADDR_W = 3;
  localparam int CFG_DATA_W = 32;
  localparam logic [0:0] CFG_IDX_CELL_ID = 1'b0;

  // input commands
  typedef enum logic {
    CMD_ADD  = 1'b0,
    CMD_READ = 1'b1
  } hit_cmd_t;

  // controller -> datapath
  typedef struct packed {
    logic hit_load;  // capture an input transaction
    logic calc_en;   // register label search results
    logic upd_en;    // apply update and load result register
    logic rd_load;   // load result register with one list slot
  } cetk_ctl_t;

  // datapath -> controller
  typedef struct packed {
    logic out_free;  // result register can take a new transaction
    logic rd_last;   // readout counter sits on the final slot
  } cetk_sts_t;

  // unsigned add clamped at all ones
  function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                               input logic [ACC_W-1:0] b);
    logic [ACC_W:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
  endfunction

endpackage

### sv/cetk_cfg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetk_cfg
// APB register file holding the cell identifier.
// ----------------------------------------------------------------------------
module cetk_cfg
  import cetk_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  psel,
  input  logic                  penable,
  input  logic                  pwrite,
  input  logic [CFG_ADDR_W-1:0] paddr,
  input  logic [CFG_DATA_W-1:0] pwdata,
  output logic [CFG_DATA_W-1:0] prdata,
  output logic                  pready,
  output logic [CELL_W-1:0]     cell_id
);

  logic [CELL_W-1:0] cell_id_r;
  logic [0:0]        reg_idx;
  logic              wr_cell;

  // word index of the access
  assign reg_idx = paddr[2];
  assign wr_cell = psel && penable && pwrite && (reg_idx == CFG_IDX_CELL_ID);
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_id_r <= '0;
    end else if (wr_cell) begin
      cell_id_r <= pwdata[CELL_W-1:0];
    end
  end

  // read mux
  always_comb begin
    prdata = '0;
    if (reg_idx == CFG_IDX_CELL_ID) begin
      prdata = {{(CFG_DATA_W-CELL_W){1'b0}}, cell_id_r};
    end
  end

  assign cell_id = cell_id_r;

endmodule

### sv/cetk_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetk_ctrl
// Sequencer: capture, label search, list update, and list readout.
// ----------------------------------------------------------------------------
module cetk_ctrl
  import cetk_pkg::*;
(
  input  logic      clk,
  input  logic      rst_n,
  input  logic      in_valid,
  input  logic      in_command,
  output logic      in_stall,
  input  cetk_sts_t sts,
  output cetk_ctl_t ctl
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CALC,
    ST_UPD,
    ST_RD
  } state_t;

  state_t state_r, state_nxt;
  logic   take;
  logic   is_read;

  assign is_read = (hit_cmd_t'(in_command) == CMD_READ);

  // input is open when idle, or when the update retires this cycle
  assign in_stall = !rst_n ||
                    !((state_r == ST_IDLE) || ((state_r == ST_UPD) && sts.out_free));
  assign take     = in_valid && !in_stall;

  // commands
  always_comb begin
    ctl.hit_load = take;
    ctl.calc_en  = (state_r == ST_CALC);
    ctl.upd_en   = (state_r == ST_UPD) && sts.out_free;
    ctl.rd_load  = (state_r == ST_RD) && sts.out_free;
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (take) state_nxt = is_read ? ST_RD : ST_CALC;
      end
      ST_CALC: begin
        state_nxt = ST_UPD;
      end
      ST_UPD: begin
        if (sts.out_free) begin
          if (take) state_nxt = is_read ? ST_RD : ST_CALC;
          else      state_nxt = ST_IDLE;
        end
      end
      ST_RD: begin
        if (sts.out_free && sts.rd_last) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

### sv/cetk_dp.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetk_dp
// Datapath: hit capture, parallel label match, sorted list insertion,
// energy/time accumulation and the result register.
// ----------------------------------------------------------------------------
module cetk_dp
  import cetk_pkg::*;
#(
  parameter int MAX_LABELS = CETK_MAX_LABELS
)(
  input  logic                       clk,
  input  logic                       rst_n,
  input  cetk_ctl_t                  ctl,
  output cetk_sts_t                  sts,
  input  logic [CELL_W-1:0]          cell_id,
  input  logic [CELL_W-1:0]          in_hit_cell,
  input  logic [ENERGY_W-1:0]        in_hit_energy,
  input  logic [TIME_W-1:0]          in_hit_time,
  input  logic signed [LABEL_W-1:0]  in_hit_label,
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_ignored,
  output logic [ACC_W-1:0]           out_total_energy,
  output logic [TIME_W-1:0]          out_digit_time,
  output logic [USED_W-1:0]          out_used_slots,
  output logic [SLOT_IDX_W-1:0]      out_slot_index,
  output logic signed [LABEL_W-1:0]  out_slot_label,
  output logic [ACC_W-1:0]           out_slot_deposit,
  output logic                       out_last
);

  localparam int IDX_W  = $clog2(MAX_LABELS);
  localparam int FILL_W = $clog2(MAX_LABELS + 1);

  // captured hit
  logic [CELL_W-1:0]         hit_cell_r;
  logic [ENERGY_W-1:0]       hit_energy_r;
  logic [TIME_W-1:0]         hit_time_r;
  logic signed [LABEL_W-1:0] hit_label_r;
  logic [ACC_W-1:0]          hit_e32;

  // accumulated state
  logic [ACC_W-1:0]          sum_r, sum_nxt;
  logic [TIME_W-1:0]         time_r, time_nxt;
  logic [FILL_W-1:0]         fill_r, fill_nxt;
  logic signed [LABEL_W-1:0] label_r [MAX_LABELS];
  logic [ACC_W-1:0]          dep_r   [MAX_LABELS];
  logic signed [LABEL_W-1:0] label_nxt [MAX_LABELS];
  logic [ACC_W-1:0]          dep_nxt   [MAX_LABELS];

  // search stage
  logic [MAX_LABELS-1:0]     lab_match;
  logic [ACC_W-1:0]          found_dep;
  logic [IDX_W-1:0]          found_idx;
  logic                      found;
  logic                      full;
  logic                      drop;
  logic                      calc_wr, calc_inc;
  logic [IDX_W-1:0]          calc_j;
  logic [ACC_W-1:0]          calc_v;
  logic                      st_drop_r, st_wr_r, st_inc_r;
  logic [IDX_W-1:0]          st_j_r;
  logic [ACC_W-1:0]          st_v_r;

  // insertion
  logic [MAX_LABELS-1:0]     ins_ge;
  logic [MAX_LABELS-1:0]     ge_up;

  // readout and result register
  logic [IDX_W-1:0]          rd_cnt_r;
  logic                      rd_last;
  logic                      out_valid_r;
  logic                      out_free;

  assign hit_e32 = {{(ACC_W-ENERGY_W){1'b0}}, hit_energy_r};

  // hit capture
  always_ff @(posedge clk) begin
    if (ctl.hit_load) begin
      hit_cell_r   <= in_hit_cell;
      hit_energy_r <= in_hit_energy;
      hit_time_r   <= in_hit_time;
      hit_label_r  <= in_hit_label;
    end
  end

  // label search across all slots in parallel
  always_comb begin
    found_dep = '0;
    found_idx = '0;
    for (int i = 0; i < MAX_LABELS; i++) begin
      lab_match[i] = (FILL_W'(i) < fill_r) && (label_r[i] == hit_label_r);
      found_dep    = found_dep | (lab_match[i] ? dep_r[i] : '0);
      found_idx    = found_idx | (lab_match[i] ? IDX_W'(i) : '0);
    end
    found = |lab_match;
    full  = (fill_r == FILL_W'(MAX_LABELS));
    drop  = (hit_cell_r != cell_id) || (hit_energy_r == '0);

    calc_inc = 1'b0;
    if (found) begin
      calc_j  = found_idx;
      calc_v  = sat_add(found_dep, hit_e32);
      calc_wr = 1'b1;
    end else if (!full) begin
      calc_j   = fill_r[IDX_W-1:0];
      calc_v   = hit_e32;
      calc_wr  = 1'b1;
      calc_inc = 1'b1;
    end else begin
      calc_j  = IDX_W'(MAX_LABELS - 1);
      calc_v  = hit_e32;
      calc_wr = (hit_e32 > dep_r[MAX_LABELS-1]);
    end
    // unlabeled or dropped hits leave the list alone
    if (drop || hit_label_r[LABEL_W-1]) begin
      calc_wr  = 1'b0;
      calc_inc = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.calc_en) begin
      st_drop_r <= drop;
      st_wr_r   <= calc_wr;
      st_inc_r  <= calc_inc;
      st_j_r    <= calc_j;
      st_v_r    <= calc_v;
    end
  end

  // insertion: the changed entry rises above every entry smaller than it
  assign ge_up = {ins_ge[MAX_LABELS-2:0], 1'b1};

  always_comb begin
    for (int i = 0; i < MAX_LABELS; i++) begin
      ins_ge[i] = (IDX_W'(i) < st_j_r) && (dep_r[i] >= st_v_r);
    end
    for (int i = 0; i < MAX_LABELS; i++) begin
      label_nxt[i] = label_r[i];
      dep_nxt[i]   = dep_r[i];
      if (st_wr_r && (IDX_W'(i) <= st_j_r) && !ins_ge[i]) begin
        if (ge_up[i]) begin
          label_nxt[i] = hit_label_r;
          dep_nxt[i]   = st_v_r;
        end else begin
          label_nxt[i] = label_r[(i == 0) ? 0 : i - 1];
          dep_nxt[i]   = dep_r[(i == 0) ? 0 : i - 1];
        end
      end
    end
    fill_nxt = fill_r + FILL_W'(st_inc_r);
    sum_nxt  = st_drop_r ? sum_r : sat_add(sum_r, hit_e32);
    time_nxt = (!st_drop_r && (hit_e32 > sum_r)) ? hit_time_r : time_r;
  end

  // accumulated state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r  <= '0;
      time_r <= '0;
      fill_r <= '0;
      for (int i = 0; i < MAX_LABELS; i++) begin
        label_r[i] <= '1;
        dep_r[i]   <= '0;
      end
    end else if (ctl.upd_en) begin
      sum_r  <= sum_nxt;
      time_r <= time_nxt;
      fill_r <= fill_nxt;
      for (int i = 0; i < MAX_LABELS; i++) begin
        label_r[i] <= label_nxt[i];
        dep_r[i]   <= dep_nxt[i];
      end
    end
  end

  // readout slot counter
  assign rd_last = (rd_cnt_r == IDX_W'(MAX_LABELS - 1));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      rd_cnt_r <= '0;
    end else if (ctl.rd_load) begin
      rd_cnt_r <= rd_last ? '0 : rd_cnt_r + 1'b1;
    end
  end

  // result register
  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (ctl.upd_en || ctl.rd_load) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.upd_en) begin
      out_ignored      <= st_drop_r;
      out_total_energy <= sum_nxt;
      out_digit_time   <= time_nxt;
      out_used_slots   <= USED_W'(fill_nxt);
      out_slot_index   <= '0;
      out_slot_label   <= label_nxt[0];
      out_slot_deposit <= dep_nxt[0];
      out_last         <= 1'b1;
    end else if (ctl.rd_load) begin
      out_ignored      <= 1'b0;
      out_total_energy <= sum_r;
      out_digit_time   <= time_r;
      out_used_slots   <= USED_W'(fill_r);
      out_slot_index   <= SLOT_IDX_W'(rd_cnt_r);
      out_slot_label   <= label_r[rd_cnt_r];
      out_slot_deposit <= dep_r[rd_cnt_r];
      out_last         <= rd_last;
    end
  end

  assign out_valid    = out_valid_r;
  assign sts.out_free = out_free;
  assign sts.rd_last  = rd_last;

endmodule

### sv/cell_energy_topk_contributors.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cell_energy_topk_contributors
// Accumulates hit energy of one cell and keeps a sorted top-k contributor list.
// ----------------------------------------------------------------------------
// Add hit: capture, search (results registered) and insertion, which waits
//   for a free result register; a new hit is taken as the update retires.
// Read: MAX_LABELS results, one per cycle unless the result channel stalls.
// Reset (rst_n low, synchronous) clears totals, time, fill count, the list
//   (labels -1, deposits 0) and cell_id; in_stall is high while rst_n is low.
module cell_energy_topk_contributors
  import cetk_pkg::*;
#(
  parameter int MAX_LABELS = CETK_MAX_LABELS
)(
  input  logic                       clk,
  input  logic                       rst_n,
  // configuration
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [CFG_ADDR_W-1:0]      paddr,
  input  logic [CFG_DATA_W-1:0]      pwdata,
  output logic [CFG_DATA_W-1:0]      prdata,
  output logic                       pready,
  // input channel
  input  logic                       in_valid,
  output logic                       in_stall,
  input  logic                       in_command,
  input  logic [CELL_W-1:0]          in_hit_cell,
  input  logic [ENERGY_W-1:0]        in_hit_energy,
  input  logic [TIME_W-1:0]          in_hit_time,
  input  logic signed [LABEL_W-1:0]  in_hit_label,
  // result channel
  output logic                       out_valid,
  input  logic                       out_stall,
  output logic                       out_ignored,
  output logic [ACC_W-1:0]           out_total_energy,
  output logic [TIME_W-1:0]          out_digit_time,
  output logic [USED_W-1:0]          out_used_slots,
  output logic [SLOT_IDX_W-1:0]      out_slot_index,
  output logic signed [LABEL_W-1:0]  out_slot_label,
  output logic [ACC_W-1:0]           out_slot_deposit,
  output logic                       out_last
);

  logic [CELL_W-1:0] cell_id;
  cetk_ctl_t         ctl;
  cetk_sts_t         sts;

  cetk_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cell_id (cell_id)
  );

  cetk_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_command (in_command),
    .in_stall   (in_stall),
    .sts        (sts),
    .ctl        (ctl)
  );

  cetk_dp #(
    .MAX_LABELS (MAX_LABELS)
  ) u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .ctl              (ctl),
    .sts              (sts),
    .cell_id          (cell_id),
    .in_hit_cell      (in_hit_cell),
    .in_hit_energy    (in_hit_energy),
    .in_hit_time      (in_hit_time),
    .in_hit_label     (in_hit_label),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_ignored      (out_ignored),
    .out_total_energy (out_total_energy),
    .out_digit_time   (out_digit_time),
    .out_used_slots   (out_used_slots),
    .out_slot_index   (out_slot_index),
    .out_slot_label   (out_slot_label),
    .out_slot_deposit (out_slot_deposit),
    .out_last         (out_last)
  );

endmodule

### sv/cetk_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cetk_chk
// Port-level checks on the result channel, bound to the top level.
// ----------------------------------------------------------------------------
module cetk_chk
  import cetk_pkg::*;
#(
  parameter int MAX_LABELS = CETK_MAX_LABELS
)(
  input logic                      clk,
  input logic                      rst_n,
  input logic                      out_valid,
  input logic                      out_stall,
  input logic                      out_ignored,
  input logic [USED_W-1:0]         out_used_slots,
  input logic [SLOT_IDX_W-1:0]     out_slot_index,
  input logic signed [LABEL_W-1:0] out_slot_label,
  input logic [ACC_W-1:0]          out_slot_deposit,
  input logic                      out_last
);

  // stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_slot_deposit) && $stable(out_last))
    else $error("result changed while stalled");

  // fill count never exceeds the list depth
  a_used_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> out_used_slots <= USED_W'(MAX_LABELS))
    else $error("used_slots beyond list depth");

  // a dropped hit gives a single result at the top slot
  a_ignored_single: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ignored |-> out_last && (out_slot_index == '0))
    else $error("dropped hit result malformed");

  // a readout ends on the bottom slot
  a_read_end: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_last && (out_slot_index != '0) |->
      out_slot_index == SLOT_IDX_W'(MAX_LABELS - 1))
    else $error("readout ended early");

  // an empty slot carries no deposit
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_slot_label == '1) |-> out_slot_deposit == '0)
    else $error("empty slot with deposit");

endmodule

bind cell_energy_topk_contributors cetk_chk #(
  .MAX_LABELS (MAX_LABELS)
) u_cetk_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .out_valid        (out_valid),
  .out_stall        (out_stall),
  .out_ignored      (out_ignored),
  .out_used_slots   (out_used_slots),
  .out_slot_index   (out_slot_index),
  .out_slot_label   (out_slot_label),
  .out_slot_deposit (out_slot_deposit),
  .out_last         (out_last)
);
